/* sv/rislp_pkg.sv */
`default_nettype none
package rislp_pkg;

   // pool geometry
   localparam int SLOTS    = 256;
   localparam int IDX_W    = $clog2(SLOTS);
   localparam int LINK_W   = IDX_W + 1;
   localparam int KEY_W    = 64;
   localparam int COUNT_W  = 16;
   localparam int SLOT_W   = 8;
   localparam int STATUS_W = 3;

   // null link marks the end of the free list
   localparam logic [LINK_W-1:0]  LINK_NULL = LINK_W'(SLOTS);
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // operation codes
   localparam logic OP_ACQUIRE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_HIT   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NEW   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_USED  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FREED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_ERR   = 3'd5;

   typedef struct packed {
      logic              op;
      logic [KEY_W-1:0]  key;
      logic [SLOT_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot_index;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count_after;
   } rsp_type;

   // saturating increment of a reference count
   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
      sat_inc = (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_W'(1);
   endfunction

endpackage
`default_nettype wire

/* sv/refcounted_interning_slot_pool_unit.sv */
`default_nettype none
// Interning pool of reference-counted slots. An acquire transaction (op 0)
// scans all slots for a valid one holding the key: a hit bumps its count, a
// miss takes the head of the free list (status new, count one), and a full
// pool bumps reserved slot 0 (status full default). A release transaction
// (op 1) lowers a slot's count and returns it to the free list at zero; a
// release of a zero count is reported as an error and changes nothing.
// One transaction is worked on at a time. An acquire's length is set by the
// key scan, which reads one entry of the key memory per cycle; a release does
// a read-modify-write of the count memory. A new request is taken while a
// finished result still waits in the output register. Keys live in one
// memory, and counts share a second memory with the free-list links; the
// valid bits sit in flip-flops, so there is no clearing pass after reset.
// Slot 0's count and key are written while reset is held.
module refcounted_interning_slot_pool_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rislp_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rislp_pkg::rsp_type      rsp_payload
);
   import rislp_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_LINK = 3'd2;
   localparam logic [2:0] S_CNT  = 3'd3;
   localparam logic [2:0] S_UPD  = 3'd4;
   localparam logic [2:0] S_RESP = 3'd5;

   localparam logic [1:0] K_HIT  = 2'd0;
   localparam logic [1:0] K_FULL = 2'd1;
   localparam logic [1:0] K_REL  = 2'd2;

   logic [2:0]         state_ff,     state_in;
   logic [1:0]         kind_ff,      kind_in;
   logic [KEY_W-1:0]   key_ff,       key_in;
   logic [IDX_W-1:0]   tgt_ff,       tgt_in;
   logic [LINK_W-1:0]  scan_ff,      scan_in;
   logic               cmp_vld_ff,   cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff,   cmp_idx_in;
   logic [SLOTS-1:0]   valid_ff,     valid_in;
   logic [LINK_W-1:0]  free_head_ff, free_head_in;
   logic [LINK_W-1:0]  fresh_ff,     fresh_in;
   rsp_type            res_ff,       res_in;
   rsp_type            rsp_ff,       rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // memory ports
   logic               key_we;
   logic [IDX_W-1:0]   key_waddr;
   logic [KEY_W-1:0]   key_wdata;
   logic [KEY_W-1:0]   key_q;
   logic               cnt_we;
   logic [IDX_W-1:0]   cnt_waddr;
   logic [IDX_W-1:0]   cnt_raddr;
   logic [COUNT_W-1:0] cnt_wdata;
   logic [LINK_W-1:0]  link_wdata;
   logic [LINK_W+COUNT_W-1:0] cl_q;
   logic [COUNT_W-1:0] cnt_q;
   logic [LINK_W-1:0]  link_q;

   logic               scan_hit;
   logic [COUNT_W-1:0] cur_cnt;
   logic [COUNT_W-1:0] dec_cnt;
   logic [COUNT_W-1:0] inc_cnt;
   logic [IDX_W-1:0]   head_idx;

   rislp_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_waddr),
      .wr_data (key_wdata),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (key_q)
   );

   // count in the low bits, free-list link in the high bits
   rislp_ram #(.WIDTH(LINK_W + COUNT_W), .DEPTH(SLOTS)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data ({link_wdata, cnt_wdata}),
      .rd_addr (cnt_raddr),
      .rd_data (cl_q)
   );

   assign cnt_q  = cl_q[COUNT_W-1:0];
   assign link_q = cl_q[LINK_W+COUNT_W-1:COUNT_W];

   // the scan reads the head's link, everything else the target's count
   assign cnt_raddr = (state_ff == S_SCAN) ? head_idx : tgt_ff;

   // key compare in the cycle after the scan read
   assign scan_hit = cmp_vld_ff && valid_ff[cmp_idx_ff] && (key_q == key_ff);
   assign head_idx = free_head_ff[IDX_W-1:0];

   // count of the target, zero for a slot that is not valid
   assign cur_cnt = valid_ff[tgt_ff] ? cnt_q : '0;
   assign inc_cnt = sat_inc(cur_cnt);
   assign dec_cnt = cur_cnt - COUNT_W'(1);

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // control sequencer
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      tgt_in       = tgt_ff;
      scan_in      = scan_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      valid_in     = valid_ff;
      free_head_in = free_head_ff;
      fresh_in     = fresh_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      key_we       = 1'b0;
      key_waddr    = head_idx;
      key_wdata    = key_ff;
      cnt_we       = 1'b0;
      cnt_waddr    = tgt_ff;
      cnt_wdata    = inc_cnt;
      link_wdata   = free_head_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in = req_payload.key;
               tgt_in = IDX_W'(req_payload.slot);
               if (req_payload.op == OP_ACQUIRE) begin
                  scan_in  = '0;
                  state_in = S_SCAN;
               end else if (32'(req_payload.slot) >= 32'(SLOTS)) begin
                  res_in.slot_index  = req_payload.slot;
                  res_in.status      = ST_ERR;
                  res_in.count_after = '0;
                  state_in           = S_RESP;
               end else begin
                  kind_in  = K_REL;
                  state_in = S_CNT;
               end
            end
         end

         S_SCAN: begin
            // issue the next key read
            if (scan_ff < LINK_NULL) begin
               scan_in    = scan_ff + LINK_W'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[IDX_W-1:0];
            end
            if (scan_hit) begin
               cmp_vld_in = 1'b0;
               tgt_in     = cmp_idx_ff;
               kind_in    = K_HIT;
               state_in   = S_CNT;
            end else if (cmp_vld_ff && (cmp_idx_ff == IDX_W'(SLOTS - 1))) begin
               cmp_vld_in = 1'b0;
               if (free_head_ff == LINK_NULL) begin
                  // pool full: fall back to the reserved slot
                  tgt_in   = '0;
                  kind_in  = K_FULL;
                  state_in = S_CNT;
               end else begin
                  // allocate the free-list head
                  key_we             = 1'b1;
                  cnt_we             = 1'b1;
                  cnt_waddr          = head_idx;
                  cnt_wdata          = COUNT_W'(1);
                  valid_in[head_idx] = 1'b1;
                  tgt_in             = head_idx;
                  res_in.slot_index  = SLOT_W'(head_idx);
                  res_in.status      = ST_NEW;
                  res_in.count_after = COUNT_W'(1);
                  if (free_head_ff == fresh_ff) begin
                     free_head_in = fresh_ff + LINK_W'(1);
                     fresh_in     = fresh_ff + LINK_W'(1);
                     state_in     = S_RESP;
                  end else begin
                     state_in = S_LINK;
                  end
               end
            end
         end

         S_LINK: begin
            // pop: link of the old head is now on the read port
            free_head_in = link_q;
            state_in     = S_RESP;
         end

         S_CNT: begin
            state_in = S_UPD;
         end

         S_UPD: begin
            res_in.slot_index = SLOT_W'(tgt_ff);
            state_in          = S_RESP;
            case (kind_ff)
               K_HIT, K_FULL: begin
                  cnt_we             = 1'b1;
                  res_in.status      = (kind_ff == K_HIT) ? ST_HIT : ST_FULL;
                  res_in.count_after = inc_cnt;
               end
               K_REL: begin
                  if (cur_cnt == '0) begin
                     res_in.status      = ST_ERR;
                     res_in.count_after = '0;
                  end else begin
                     cnt_we             = 1'b1;
                     cnt_wdata          = dec_cnt;
                     res_in.count_after = dec_cnt;
                     if (dec_cnt != '0) begin
                        res_in.status = ST_USED;
                     end else begin
                        // push the slot on the free list
                        res_in.status    = ST_FREED;
                        valid_in[tgt_ff] = 1'b0;
                        free_head_in     = LINK_W'(tgt_ff);
                     end
                  end
               end
               default: begin
                  res_in.status      = ST_ERR;
                  res_in.count_after = '0;
               end
            endcase
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // reserved slot 0 starts with count one and key zero
      if (reset) begin
         key_we     = 1'b1;
         key_waddr  = '0;
         key_wdata  = '0;
         cnt_we     = 1'b1;
         cnt_waddr  = '0;
         cnt_wdata  = COUNT_W'(1);
         link_wdata = LINK_NULL;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cmp_vld_ff   <= 1'b0;
         valid_ff     <= SLOTS'(1);
         free_head_ff <= LINK_W'(1);
         fresh_ff     <= LINK_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmp_vld_ff   <= cmp_vld_in;
         valid_ff     <= valid_in;
         free_head_ff <= free_head_in;
         fresh_ff     <= fresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      key_ff     <= key_in;
      tgt_ff     <= tgt_in;
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   // a hit always lands on a valid slot
   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPD && kind_ff == K_HIT) |-> valid_ff[tgt_ff])
      else $error("hit on a slot that is not valid");

   // the never-allocated region only grows up to the null link
   a_fresh_range: assert property (@(posedge clock) disable iff (reset)
      fresh_ff <= LINK_NULL)
      else $error("fresh slot counter out of range");

   // a result only appears from the response state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_RESP)
      else $error("result raised outside the response state");

   // the free-list head is either null or a slot that is not in use,
   // except while a pop waits for the next link
   a_head_free: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff != LINK_NULL && state_ff != S_LINK) |-> !valid_ff[head_idx])
      else $error("free-list head points at a valid slot");

endmodule
`default_nettype wire

/* sv/rislp_ram.sv */
`default_nettype none
module rislp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

/* verif/tb_top.sv */
module tb_top;
   import rislp_pkg::*;

   localparam int RANDOM_ITEMS = 1030;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int DRAIN_CYCLES = 300;
   localparam int RESET_CYCLES = 12;
   // two copies of the pool: one steers stimulus, one predicts results
   localparam int PLAN  = 0;
   localparam int CHECK = 1;

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   // pool state per copy
   logic [COUNT_W-1:0] pool_count [2][SLOTS];
   logic [KEY_W-1:0]   pool_key   [2][SLOTS];
   bit                 pool_live  [2][SLOTS];
   int                 pool_link  [2][SLOTS];
   int                 pool_head  [2];

   req_type pending_reqs [$];
   rsp_type awaited_rsps [$];
   int      accepted_reqs = 0;
   int      total_reqs    = 0;
   int      errors        = 0;
   int      cycle_count   = 0;
   int      status_seen [6];

   refcounted_interning_slot_pool_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // pool after reset: slot 0 held once, every other slot chained on the free list
   task automatic pool_reset(input int c);
      for (int i = 0; i < SLOTS; i++) begin
         pool_count[c][i] = '0;
         pool_key[c][i]   = '0;
         pool_live[c][i]  = 1'b0;
         pool_link[c][i]  = i + 1;
      end
      pool_count[c][0] = COUNT_W'(1);
      pool_live[c][0]  = 1'b1;
      pool_head[c]     = 1;
   endtask

   function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] n);
      return (n == COUNT_MAX) ? COUNT_MAX : n + COUNT_W'(1);
   endfunction

   // apply one transaction to a pool copy and return the result it yields
   function automatic rsp_type pool_step(input int c, input req_type r);
      rsp_type res;
      int      idx;
      int      s;
      res = '0;
      if (r.op == OP_ACQUIRE) begin
         idx = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (idx < 0 && pool_live[c][i] && pool_key[c][i] == r.key) idx = i;
         end
         if (idx >= 0) begin
            pool_count[c][idx] = count_inc(pool_count[c][idx]);
            res.slot_index     = SLOT_W'(idx);
            res.status         = ST_HIT;
            res.count_after    = pool_count[c][idx];
         end else if (pool_head[c] >= SLOTS) begin
            // no free slot left: fall back to reserved slot 0
            pool_count[c][0] = count_inc(pool_count[c][0]);
            res.slot_index   = '0;
            res.status       = ST_FULL;
            res.count_after  = pool_count[c][0];
         end else begin
            idx                = pool_head[c];
            pool_head[c]       = pool_link[c][idx];
            pool_key[c][idx]   = r.key;
            pool_live[c][idx]  = 1'b1;
            pool_count[c][idx] = COUNT_W'(1);
            res.slot_index     = SLOT_W'(idx);
            res.status         = ST_NEW;
            res.count_after    = COUNT_W'(1);
         end
      end else begin
         s = int'(r.slot);
         res.slot_index = r.slot;
         if (s >= SLOTS || pool_count[c][s] == '0) begin
            res.status = ST_ERR;
         end else begin
            pool_count[c][s] = pool_count[c][s] - COUNT_W'(1);
            res.count_after  = pool_count[c][s];
            if (pool_count[c][s] != '0) begin
               res.status = ST_USED;
            end else begin
               // last reference gone: push the slot on the free list
               pool_live[c][s] = 1'b0;
               pool_link[c][s] = pool_head[c];
               pool_head[c]    = s;
               res.status      = ST_FREED;
            end
         end
      end
      return res;
   endfunction

   // queue a transaction and advance the steering copy
   task automatic queue_item(input logic op, input logic [KEY_W-1:0] key,
                             input logic [SLOT_W-1:0] slot);
      req_type r;
      r.op   = op;
      r.key  = key;
      r.slot = slot;
      void'(pool_step(PLAN, r));
      pending_reqs.push_back(r);
   endtask

   function automatic logic [KEY_W-1:0] fresh_key();
      return {$urandom, $urandom};
   endfunction

   // some slot holding a reference, or -1 when none does
   function automatic int pick_live_slot();
      int start;
      int idx;
      start = $urandom_range(0, SLOTS - 1);
      for (int k = 0; k < SLOTS; k++) begin
         idx = (start + k) % SLOTS;
         if (pool_count[PLAN][idx] != '0) return idx;
      end
      return -1;
   endfunction

   function automatic int live_total();
      int n;
      n = 0;
      for (int i = 0; i < SLOTS; i++) begin
         if (pool_live[PLAN][i]) n++;
      end
      return n;
   endfunction

   // idle percentage for the current third of the run
   function automatic int idle_pct(input bit sender);
      int phase;
      phase = (total_reqs == 0) ? 0 : accepted_reqs * 3 / total_reqs;
      if (phase == 0) return sender ? 26 : 88;
      if (phase == 1) return sender ? 88 : 26;
      return 0;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // stimulus, reset and end of run
   initial begin
      int  roll;
      int  s;
      int  full_run;
      bit  filling;
      logic [KEY_W-1:0] k;

      pool_reset(PLAN);
      pool_reset(CHECK);
      for (int i = 0; i < 6; i++) status_seen[i] = 0;

      // directed: hits, allocation, freeing, reuse, release errors, slot 0 freed
      queue_item(OP_ACQUIRE, '0, 8'hFF);
      queue_item(OP_ACQUIRE, '1, 8'h00);
      queue_item(OP_ACQUIRE, '1, 8'h55);
      queue_item(OP_ACQUIRE, {1'b1, 63'b0}, 8'h01);
      queue_item(OP_RELEASE, '1, 8'd1);
      queue_item(OP_RELEASE, '0, 8'd1);
      queue_item(OP_RELEASE, '1, 8'd1);
      queue_item(OP_RELEASE, '0, 8'd255);
      queue_item(OP_ACQUIRE, {16{4'h5}}, 8'hAA);
      queue_item(OP_RELEASE, '0, 8'd0);
      queue_item(OP_RELEASE, '1, 8'd0);
      queue_item(OP_ACQUIRE, '0, 8'h80);
      queue_item(OP_ACQUIRE, '0, 8'h7F);
      queue_item(OP_RELEASE, {16{4'hA}}, 8'hAA);
      queue_item(OP_ACQUIRE, {16{4'hA}}, 8'h55);
      queue_item(OP_RELEASE, '0, 8'd2);
      queue_item(OP_RELEASE, '1, 8'd2);

      // random: fill the pool to full, sit there a while, drain it, repeat
      filling  = 1'b1;
      full_run = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll = $urandom_range(0, 99);
         if (filling && pool_head[PLAN] >= SLOTS) begin
            full_run++;
            if (full_run > 40) filling = 1'b0;
         end
         if (!filling && live_total() < 6) begin
            filling  = 1'b1;
            full_run = 0;
         end
         s = pick_live_slot();
         k = (s >= 0) ? pool_key[PLAN][s] : fresh_key();
         if (roll < 8) begin
            // noise: release of any slot, often one with no reference
            queue_item(OP_RELEASE, fresh_key(), SLOT_W'($urandom_range(0, SLOTS - 1)));
         end else if (filling) begin
            if (roll < 78 || s < 0)
               queue_item(OP_ACQUIRE, fresh_key(), SLOT_W'($urandom));
            else if (roll < 88)
               queue_item(OP_ACQUIRE, k, SLOT_W'($urandom));
            else
               queue_item(OP_RELEASE, fresh_key(), SLOT_W'(s));
         end else begin
            if (s >= 0 && roll < 75)
               queue_item(OP_RELEASE, fresh_key(), SLOT_W'(s));
            else if (s >= 0 && roll < 85)
               queue_item(OP_ACQUIRE, k, SLOT_W'($urandom));
            else
               queue_item(OP_ACQUIRE, fresh_key(), SLOT_W'($urandom));
         end
      end
      total_reqs = pending_reqs.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (awaited_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (awaited_rsps.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, awaited_rsps.size());
         errors++;
      end
      $display("acquires seen: %0d hits, %0d new slots, %0d full-pool defaults",
               status_seen[ST_HIT], status_seen[ST_NEW], status_seen[ST_FULL]);
      $display("releases seen: %0d still used, %0d freed, %0d rejected (%0d transactions)",
               status_seen[ST_USED], status_seen[ST_FREED], status_seen[ST_ERR], total_reqs);
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // request driver: predict each accepted transaction, then offer the next
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_rsps.push_back(pool_step(CHECK, req_payload));
            accepted_reqs++;
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
               req_valid   <= 1'b1;
               req_payload <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor: compare against the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsps.size() == 0) begin
               $display("%0t: unexpected result: slot %0d status %0d count %0d", $time,
                        rsp_payload.slot_index, rsp_payload.status, rsp_payload.count_after);
               errors++;
            end else begin
               want = awaited_rsps.pop_front();
               check_field("slot_index", 32'(want.slot_index), 32'(rsp_payload.slot_index));
               check_field("status", 32'(want.status), 32'(rsp_payload.status));
               check_field("count_after", 32'(want.count_after),
                           32'(rsp_payload.count_after));
               if (rsp_payload.status <= ST_ERR) status_seen[rsp_payload.status]++;
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
